// ===== rtl/core/qre_pkg.sv =====
// ----------------------------------------------------------------------------
// qre_pkg
// Constants and the CORDIC arctangent table for the quaternion to
// roll, pitch and yaw converter.
// ----------------------------------------------------------------------------
package qre_pkg;

  localparam int ATAN_TAB_LEN = 24;

  // Angle units: 2^31 stands for pi.
  localparam longint HALF_PI_ACC  = 64'sd1073741824;
  // 1/K, K taken at infinite stages.
  localparam logic [27:0] INV_GAIN_Q28 = 28'd163008219;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [29:0] atan_entry(input int unsigned idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/qre_cordic.sv =====
// ----------------------------------------------------------------------------
// qre_cordic
// Pipelined CORDIC, one register stage per iteration plus an entry stage.
// Vectoring mode (with quarter-turn pre-rotation and zero-vector flag) or
// rotation mode; carries a side bus alongside the data.
// ----------------------------------------------------------------------------
module qre_cordic #(
  parameter int W      = 37,
  parameter int AW     = 34,
  parameter int N      = 16,
  parameter int SW     = 1,
  parameter bit VECTOR = 1'b1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic signed [W-1:0]  x_in,
  input  logic signed [W-1:0]  y_in,
  input  logic signed [AW-1:0] z_in,
  input  logic [SW-1:0]        side_in,
  output logic                 valid_out,
  output logic signed [W-1:0]  x_out,
  output logic signed [W-1:0]  y_out,
  output logic signed [AW-1:0] z_out,
  output logic [SW-1:0]        side_out
);
  import qre_pkg::*;

  logic signed [W-1:0]  xr [0:N];
  logic signed [W-1:0]  yr [0:N];
  logic signed [AW-1:0] zr [0:N];
  logic [SW-1:0]        sr [0:N];
  logic                 vr [0:N];
  logic                 zf [0:N];

  logic signed [W-1:0]  x_pre;
  logic signed [W-1:0]  y_pre;
  logic signed [AW-1:0] z_pre;
  logic                 zero_pre;

  always_comb begin
    x_pre    = x_in;
    y_pre    = y_in;
    z_pre    = z_in;
    zero_pre = 1'b0;
    if (VECTOR) begin
      zero_pre = (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_pre = y_in;
          y_pre = -x_in;
          z_pre = z_in + AW'(HALF_PI_ACC);
        end else begin
          x_pre = -y_in;
          y_pre = x_in;
          z_pre = z_in - AW'(HALF_PI_ACC);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (en) begin
      vr[0] <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr[0] <= x_pre;
      yr[0] <= y_pre;
      zr[0] <= z_pre;
      sr[0] <= side_in;
      zf[0] <= zero_pre;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [AW-1:0] TAB = AW'(atan_entry(k));
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic                ccw;

    assign xs  = xr[k] >>> k;
    assign ys  = yr[k] >>> k;
    assign ccw = VECTOR ? !(yr[k] > 0) : (zr[k] >= 0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k+1] <= 1'b0;
      end else if (en) begin
        vr[k+1] <= vr[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (ccw) begin
          xr[k+1] <= xr[k] - ys;
          yr[k+1] <= yr[k] + xs;
          zr[k+1] <= zr[k] - TAB;
        end else begin
          xr[k+1] <= xr[k] + ys;
          yr[k+1] <= yr[k] - xs;
          zr[k+1] <= zr[k] + TAB;
        end
        sr[k+1] <= sr[k];
        zf[k+1] <= zf[k];
      end
    end
  end

  assign valid_out = vr[N];
  assign x_out     = zf[N] ? '0 : xr[N];
  assign y_out     = yr[N];
  assign z_out     = zf[N] ? '0 : zr[N];
  assign side_out  = sr[N];

endmodule

// ===== rtl/core/quaternion_to_roll_pitch_yaw.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_roll_pitch_yaw
// The data path runs through four CORDIC pipelines in series plus eleven
// multiply, round and register stages.
// Throughput one request per cycle; the whole pipeline holds while the
// output request waits, so tready low on the master side stops the slave.
// Reset (synchronous, rst high) clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
module quaternion_to_roll_pitch_yaw #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // roll_angle, pitch_angle, yaw_angle
);
  import qre_pkg::*;

  localparam int NS = (CORDIC_STAGES > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STAGES;

  // Advance every stage unless the output register holds an untaken request.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: capture the request.
  logic        v1;
  logic [63:0] q1;

  // Stage 2: squares and cross products.
  logic               v2;
  logic [63:0]        q2;
  logic signed [31:0] pyy, pzz, pxy, pwz, pxz, pwy;

  // Stage 3: first rotation-matrix column (Q30).
  logic               v3;
  logic [63:0]        q3;
  logic signed [33:0] c0, c1, c2;
  logic signed [32:0] s_yz, s_xywz, s_xzwy;

  // Yaw vectoring
  logic               yv;
  logic signed [36:0] ymag;
  logic signed [33:0] yacc;
  logic [97:0]        yside;

  // Stage 4: yaw angle and magnitude scaling.
  logic               v4;
  logic [63:0]        q4;
  logic signed [33:0] c2_4;
  logic signed [17:0] yaw4;
  logic [61:0]        prod4;
  logic signed [33:0] yacc_r;
  logic [61:0]        prod_r;
  logic [61:0]        prod_hold;

  // Stage 5: horizontal length.
  logic               v5;
  logic [63:0]        q5;
  logic signed [17:0] yaw5;
  logic [33:0]        horiz;
  logic signed [36:0] negc2;

  // Pitch vectoring
  logic               pv;
  logic signed [33:0] pacc;
  logic [81:0]        pside;

  // Stage 6: pitch angle.
  logic               v6;
  logic [63:0]        q6;
  logic signed [17:0] yaw6, pitch6;
  logic signed [33:0] pacc_r;

  // Half-angle sine and cosine
  logic signed [35:0] yaw_ang, pitch_ang;
  logic               scy_v, scp_v;
  logic signed [32:0] ca, sa, cb, sb;
  logic [81:0]        scy_side;
  logic [17:0]        scp_side;

  // Stage 7: de-rotation about z, products.
  logic               v7;
  logic signed [32:0] cb7, sb7;
  logic signed [17:0] yaw7, pitch7;
  logic signed [48:0] m_cw, m_sz, m_sw, m_cz, m_cx, m_sy, m_sx, m_cy;

  // Stage 8: rounded Q30 components.
  logic               v8;
  logic signed [32:0] cb8, sb8;
  logic signed [17:0] yaw8, pitch8;
  logic signed [34:0] w1, z1, x1, y1;
  logic signed [49:0] t_w, t_z, t_x, t_y;

  // Stage 9: de-rotation about y, products.
  logic               v9;
  logic signed [17:0] yaw9, pitch9;
  logic signed [67:0] n_bw, n_sy, n_bx, n_sz;

  // Stage 10: remaining w and x.
  logic               v10;
  logic signed [17:0] yaw10, pitch10;
  logic signed [36:0] w2, x2;
  logic signed [68:0] t_w2, t_x2;

  // Roll vectoring
  logic               rv;
  logic signed [33:0] racc;
  logic [31:0]        rside;
  logic signed [33:0] racc_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2; v4 <= yv; v5 <= v4;
      v6 <= pv; v7 <= scy_v; v8 <= v7; v9 <= v8; v10 <= v9;
      m_tvalid <= rv;
    end
  end

  assign s_yz   = 33'(pyy) + 33'(pzz);
  assign s_xywz = 33'(pxy) + 33'(pwz);
  assign s_xzwy = 33'(pxz) - 33'(pwy);

  always_ff @(posedge clk) begin
    if (en) begin
      q1  <= s_tdata;
      q2  <= q1;
      pyy <= $signed(q1[47:32]) * $signed(q1[47:32]);
      pzz <= $signed(q1[63:48]) * $signed(q1[63:48]);
      pxy <= $signed(q1[31:16]) * $signed(q1[47:32]);
      pwz <= $signed(q1[15:0])  * $signed(q1[63:48]);
      pxz <= $signed(q1[31:16]) * $signed(q1[63:48]);
      pwy <= $signed(q1[15:0])  * $signed(q1[47:32]);
      q3  <= q2;
      c0  <= 34'sd1073741824 - $signed({s_yz, 1'b0});
      c1  <= $signed({s_xywz, 1'b0});
      c2  <= $signed({s_xzwy, 1'b0});
    end
  end

  qre_cordic #(.W(37), .AW(34), .N(NS), .SW(98), .VECTOR(1'b1)) u_yaw (
    .clk(clk), .rst(rst), .en(en), .valid_in(v3),
    .x_in(37'(c0)), .y_in(37'(c1)), .z_in('0), .side_in({c2, q3}),
    .valid_out(yv), .x_out(ymag), .y_out(), .z_out(yacc), .side_out(yside)
  );

  function automatic logic [61:0] prod4_reg_round(input logic [61:0] p);
    return p + 62'd134217728;
  endfunction

  // Round half up: add half an LSB, then drop the low bits.
  assign yacc_r = yacc + 34'sd32768;
  assign prod4  = 62'(ymag[33:0]) * 62'(INV_GAIN_Q28);
  assign prod_r = prod4_reg_round(prod_hold);

  always_ff @(posedge clk) begin
    if (en) begin
      q4        <= yside[63:0];
      c2_4      <= $signed(yside[97:64]);
      yaw4      <= yacc_r[33:16];
      prod_hold <= prod4;
      q5        <= q4;
      yaw5      <= yaw4;
      horiz     <= prod_r[61:28];
      negc2     <= -37'(c2_4);
    end
  end

  qre_cordic #(.W(37), .AW(34), .N(NS), .SW(82), .VECTOR(1'b1)) u_pitch (
    .clk(clk), .rst(rst), .en(en), .valid_in(v5),
    .x_in(37'({3'b000, horiz})), .y_in(negc2), .z_in('0), .side_in({yaw5, q5}),
    .valid_out(pv), .x_out(), .y_out(), .z_out(pacc), .side_out(pside)
  );

  assign pacc_r = pacc + 34'sd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      q6     <= pside[63:0];
      yaw6   <= $signed(pside[81:64]);
      pitch6 <= pacc_r[33:16];
    end
  end

  // Drive the rotators with minus half of each angle, scaled to accumulator units.
  assign yaw_ang   = -(36'(yaw6) <<< 15);
  assign pitch_ang = -(36'(pitch6) <<< 15);

  qre_cordic #(.W(33), .AW(36), .N(NS), .SW(82), .VECTOR(1'b0)) u_sc_yaw (
    .clk(clk), .rst(rst), .en(en), .valid_in(v6),
    .x_in(33'(INV_GAIN_Q30)), .y_in('0), .z_in(yaw_ang), .side_in({yaw6, q6}),
    .valid_out(scy_v), .x_out(ca), .y_out(sa), .z_out(), .side_out(scy_side)
  );

  qre_cordic #(.W(33), .AW(36), .N(NS), .SW(18), .VECTOR(1'b0)) u_sc_pitch (
    .clk(clk), .rst(rst), .en(en), .valid_in(v6),
    .x_in(33'(INV_GAIN_Q30)), .y_in('0), .z_in(pitch_ang), .side_in(pitch6),
    .valid_out(scp_v), .x_out(cb), .y_out(sb), .z_out(), .side_out(scp_side)
  );

  assign t_w = 50'(m_cw) - 50'(m_sz) + 50'sd16384;
  assign t_z = 50'(m_sw) + 50'(m_cz) + 50'sd16384;
  assign t_x = 50'(m_cx) - 50'(m_sy) + 50'sd16384;
  assign t_y = 50'(m_sx) + 50'(m_cy) + 50'sd16384;

  assign t_w2 = 69'(n_bw) - 69'(n_sy) + 69'sd536870912;
  assign t_x2 = 69'(n_bx) + 69'(n_sz) + 69'sd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      // rotate (w,z) and (x,y) by minus half yaw
      m_cw   <= ca * $signed(scy_side[15:0]);
      m_sz   <= sa * $signed(scy_side[63:48]);
      m_sw   <= sa * $signed(scy_side[15:0]);
      m_cz   <= ca * $signed(scy_side[63:48]);
      m_cx   <= ca * $signed(scy_side[31:16]);
      m_sy   <= sa * $signed(scy_side[47:32]);
      m_sx   <= sa * $signed(scy_side[31:16]);
      m_cy   <= ca * $signed(scy_side[47:32]);
      cb7    <= cb;
      sb7    <= sb;
      yaw7   <= $signed(scy_side[81:64]);
      pitch7 <= $signed(scp_side);

      w1     <= t_w[49:15];
      z1     <= t_z[49:15];
      x1     <= t_x[49:15];
      y1     <= t_y[49:15];
      cb8    <= cb7;
      sb8    <= sb7;
      yaw8   <= yaw7;
      pitch8 <= pitch7;

      // combine w and x with minus half pitch
      n_bw   <= cb8 * w1;
      n_sy   <= sb8 * y1;
      n_bx   <= cb8 * x1;
      n_sz   <= sb8 * z1;
      yaw9   <= yaw8;
      pitch9 <= pitch8;

      w2      <= 37'(t_w2[68:30]);
      x2      <= 37'(t_x2[68:30]);
      yaw10   <= yaw9;
      pitch10 <= pitch9;
    end
  end

  qre_cordic #(.W(37), .AW(34), .N(NS), .SW(32), .VECTOR(1'b1)) u_roll (
    .clk(clk), .rst(rst), .en(en), .valid_in(v10),
    .x_in(w2), .y_in(x2), .z_in('0), .side_in({yaw10[15:0], pitch10[15:0]}),
    .valid_out(rv), .x_out(), .y_out(), .z_out(racc), .side_out(rside)
  );

  // Shift by 15, not 16: roll is twice the half angle; wrap to 16 bits.
  assign racc_r = racc + 34'sd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {rside[31:16], rside[15:0], racc_r[30:15]};
    end
  end

  // Both half-angle rotators run in lock step.
  a_sc_lockstep: assert property (@(posedge clk) disable iff (rst)
    scy_v == scp_v)
    else $error("half-angle rotators out of step");

  // A held pipeline moves no valid bit through the pitch stages.
  a_hold_pitch: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pv))
    else $error("pitch valid moved during hold");

  // A new output request comes only from the roll stage.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(rv))
    else $error("output valid without roll result");

endmodule
